// ----- rtl/core/fmp_pkg.sv -----
`default_nettype none

package fmp_pkg;

  // Number of table entries, atomic numbers 1 to 36
  localparam int ELEM_COUNT = 36;
  localparam int MASS_W     = 23;
  localparam int MILLI_W    = 17;

  typedef enum logic [1:0] {
    PH_GAP,
    PH_SYM,
    PH_CNT,
    PH_STOP
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BADSYM,
    ST_UNKNOWN
  } status_e;

  localparam logic REC_RUN = 1'b0;
  localparam logic REC_SUM = 1'b1;

  typedef struct packed {
    logic              record_kind;
    logic [5:0]        element_number;
    logic [6:0]        atoms_added;
    status_e           parse_status;
    logic [6:0]        atom_total;
    logic [MASS_W-1:0] mass_milli;
    logic              final_record;
  } rec_t;

  // First and second letter of each symbol, 0 where the symbol has one letter
  localparam logic [7:0] ELEM_SYM_A [ELEM_COUNT+1] = '{
    8'h00, "H", "H", "L", "B", "B", "C", "N", "O", "F", "N",
    "N", "M", "A", "S", "P", "S", "C", "A", "K", "C",
    "S", "T", "V", "C", "M", "F", "C", "N", "C", "Z",
    "G", "G", "A", "S", "B", "K"
  };

  localparam logic [7:0] ELEM_SYM_B [ELEM_COUNT+1] = '{
    8'h00, 8'h00, "e", "i", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "e",
    "a", "g", "l", "i", 8'h00, 8'h00, "l", "r", 8'h00, "a",
    "c", "i", 8'h00, "r", "n", "e", "o", "i", "u", "n",
    "a", "e", "s", "e", "r", "r"
  };

  // Molar masses in thousandths of a unit
  localparam logic [MILLI_W-1:0] ELEM_MILLI [ELEM_COUNT+1] = '{
    17'd0,
    17'd1008,  17'd4003,  17'd6940,  17'd9012,  17'd10810, 17'd12011,
    17'd14007, 17'd15999, 17'd18998, 17'd20180, 17'd22990, 17'd24305,
    17'd26982, 17'd28086, 17'd30974, 17'd32060, 17'd35450, 17'd39948,
    17'd39098, 17'd40078, 17'd44956, 17'd47867, 17'd50942, 17'd51996,
    17'd54938, 17'd55845, 17'd58933, 17'd58693, 17'd63546, 17'd65380,
    17'd69723, 17'd72630, 17'd74922, 17'd78971, 17'd79904, 17'd83798
  };

  // Match a symbol of one or two letters against the table; 0 if not found
  function automatic logic [5:0] fmp_lookup(input logic [15:0] chars,
                                            input logic [1:0]  len);
    logic [5:0] hit;
    logic       one_hit;
    logic       two_hit;
    hit = '0;
    for (int i = 1; i <= ELEM_COUNT; i++) begin
      one_hit = (len == 2'd1) && (chars[7:0] == ELEM_SYM_A[i]) &&
                (ELEM_SYM_B[i] == 8'h00);
      two_hit = (len == 2'd2) && (chars[7:0] == ELEM_SYM_A[i]) &&
                (chars[15:8] == ELEM_SYM_B[i]) && (ELEM_SYM_B[i] != 8'h00);
      if (one_hit || two_hit) begin
        hit = hit | 6'(i);
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fmp_char_if.sv -----
`default_nettype none

interface fmp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fmp_rec_if.sv -----
`default_nettype none

interface fmp_rec_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [5:0]  element_number;
  logic [6:0]  atoms_added;
  logic [1:0]  parse_status;
  logic [6:0]  atom_total;
  logic [22:0] mass_milli;
  logic        final_record;

  modport source (output valid, output record_kind, output element_number,
                  output atoms_added, output parse_status, output atom_total,
                  output mass_milli, output final_record, input ready);
  modport sink   (input valid, input record_kind, input element_number,
                  input atoms_added, input parse_status, input atom_total,
                  input mass_milli, input final_record, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/formula_molar_mass_parser.sv -----
// Chemical formula parser: one ASCII character per item on char_i, with
// last_char set on the final character of a formula. Records leave on rec_o:
// an element run record when a character closes a run, and a summary record
// (status, atom total, molar mass in thousandths) on every last character.
// A last character that also closes a run gives the run record first and
// then the summary, so one item yields zero, one or two records.
// Throughput: one character per cycle while char_i.ready is high. Symbol match,
// count update and the count-times-mass product are combinational between the
// state registers and a four-entry record queue; a record is written to the
// queue when its character is accepted and shows on rec_o behind any earlier ones.
// char_i.ready stays high while at most two records are queued, so input
// keeps flowing while a record waits; a two-record item drains one record per
// pop on rec_o. When the receiver stalls the queue fills and char_i.ready
// drops until room for two records is back.
// Reset (rst_ni low) clears the parse state and empties the queue; the next
// character starts a new formula. After a last character the parse state
// returns to its reset values on its own.
`default_nettype none

module formula_molar_mass_parser #(
  parameter int MAX_ATOMS      = 64,
  parameter int SYMBOL_LETTERS = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fmp_char_if.sink   char_i,
  fmp_rec_if.source  rec_o
);
  import fmp_pkg::*;

  localparam int AW   = $clog2(MAX_ATOMS + 1);
  localparam int SYMW = SYMBOL_LETTERS * 8;
  localparam logic [AW-1:0] MaxAtoms   = AW'(MAX_ATOMS);
  localparam logic [1:0]    SymLenMax  = 2'(SYMBOL_LETTERS);
  localparam logic [AW+3:0] Ten        = (AW+4)'(10);
  localparam int            FIFO_DEPTH = 4;
  localparam logic [2:0]    FifoRoom   = 3'(FIFO_DEPTH - 2);

  // Parse state
  phase_e            phase_q, phase_d;
  logic [SYMW-1:0]   sym_q, sym_d;
  logic [1:0]        len_q, len_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     atoms_q, atoms_d;
  logic [MASS_W-1:0] mass_q, mass_d;
  status_e           err_q, err_d;

  // Record queue
  rec_t       fifo_q [FIFO_DEPTH];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;

  logic [7:0] c;
  logic       last;
  logic       acc;
  logic       pop;
  logic       is_lower, is_upper, is_digit, is_space, is_nul;

  assign c    = char_i.char_code;
  assign last = char_i.last_char;
  assign acc  = char_i.valid && char_i.ready;
  assign pop  = rec_o.valid && rec_o.ready;

  assign is_lower = c inside {[8'h61:8'h7A]};
  assign is_upper = c inside {[8'h41:8'h5A]};
  assign is_digit = c inside {[8'h30:8'h39]};
  assign is_space = c inside {8'h20, [8'h09:8'h0D]};
  assign is_nul   = (c == 8'h00);

  // Atoms a run may add: its count (0 meaning 1) clipped to the room left
  function automatic logic [AW-1:0] take_atoms(input logic [AW-1:0] cnt,
                                               input logic [AW-1:0] have);
    logic [AW-1:0] n_v;
    logic [AW-1:0] room_v;
    n_v    = (cnt == '0) ? AW'(1) : cnt;
    room_v = (have < MaxAtoms) ? (MaxAtoms - have) : '0;
    return (n_v < room_v) ? n_v : room_v;
  endfunction

  // Symbol with this character appended, and its table entry
  logic [SYMW-1:0] sym_app;
  logic [1:0]      len_app;
  logic            append;
  logic [5:0]      elem_a;

  assign append = (phase_q == PH_SYM) && is_lower && (len_q < SymLenMax);

  always_comb begin
    sym_app = sym_q;
    len_app = len_q;
    if (append) begin
      for (int k = 0; k < SYMBOL_LETTERS; k++) begin
        if (2'(k) == len_q) begin
          sym_app[k*8 +: 8] = c;
        end
      end
      len_app = len_q + 2'd1;
    end
  end

  assign elem_a = fmp_lookup(sym_app[15:0], len_app);

  // Control pass: phase, counts and atom totals for this character
  phase_e          ph;
  logic [SYMW-1:0] sym;
  logic [1:0]      len;
  logic [AW-1:0]   cnt;
  logic [AW-1:0]   atoms;
  logic [AW-1:0]   atoms_run;
  status_e         err;
  logic            used;
  logic            fin1, fin2;
  logic [AW-1:0]   a1, a2;
  logic [5:0]      e2;
  logic [AW+3:0]   cnt_v;

  always_comb begin
    ph        = phase_q;
    sym       = sym_q;
    len       = len_q;
    cnt       = cnt_q;
    atoms     = atoms_q;
    err       = err_q;
    used      = 1'b0;
    fin1      = 1'b0;
    fin2      = 1'b0;
    a1        = '0;
    a2        = '0;
    e2        = elem_a;
    cnt_v     = '0;

    // Extend the symbol, check it once it is complete
    if (ph == PH_SYM) begin
      used = append;
      sym  = sym_app;
      len  = len_app;
      if (!used || (len >= SymLenMax)) begin
        if (elem_a == '0) begin
          err  = ST_UNKNOWN;
          ph   = PH_STOP;
          used = 1'b1;
        end else begin
          ph  = PH_CNT;
          cnt = '0;
        end
      end
    end

    // Accumulate the count, or close the run
    if (!used && (ph == PH_CNT)) begin
      if (is_digit) begin
        cnt_v = ({4'd0, cnt} * Ten) + (AW+4)'(c[3:0]);
        cnt   = (cnt_v > (AW+4)'(MAX_ATOMS)) ? MaxAtoms : AW'(cnt_v);
        used  = 1'b1;
      end else begin
        fin1  = 1'b1;
        a1    = take_atoms(cnt, atoms);
        atoms = atoms + a1;
        ph    = (atoms >= MaxAtoms) ? PH_STOP : PH_GAP;
      end
    end
    atoms_run = atoms;

    // Between runs: skip whitespace, stop at NUL, start a symbol or flag the character
    if (!used && (ph == PH_GAP)) begin
      if (is_space) begin
        ph = PH_GAP;
      end else if (is_nul) begin
        ph = PH_STOP;
      end else if (is_upper) begin
        sym = SYMW'(c);
        len = 2'd1;
        cnt = '0;
        ph  = PH_SYM;
      end else begin
        err = ST_BADSYM;
        ph  = PH_STOP;
      end
    end

    // End of formula: close any open run into the summary
    if (last) begin
      if (ph == PH_SYM) begin
        e2 = fmp_lookup(sym[15:0], len);
        if (e2 == '0) begin
          err = ST_UNKNOWN;
          ph  = PH_STOP;
        end else begin
          ph  = PH_CNT;
          cnt = '0;
        end
      end
      if (ph == PH_CNT) begin
        fin2  = 1'b1;
        a2    = take_atoms(cnt, atoms);
        atoms = atoms + a2;
      end
    end
  end

  // Mass path: one shared product; a run closed after another adds one atom
  logic [AW-1:0]      mul_a;
  logic [MILLI_W-1:0] mul_m, m1, m2;
  logic [AW+16:0]     prod;
  logic [MASS_W-1:0]  mass_run, mass_sum, extra2;

  assign m1    = ELEM_MILLI[elem_a];
  assign m2    = ELEM_MILLI[e2];
  assign mul_a = fin1 ? a1 : a2;
  assign mul_m = fin1 ? m1 : m2;
  assign prod  = (AW+17)'(mul_a) * (AW+17)'(mul_m);

  always_comb begin
    mass_run = mass_q + (fin1 ? MASS_W'(prod) : '0);
    if (!fin2) begin
      extra2 = '0;
    end else if (fin1) begin
      extra2 = (a2 != '0) ? MASS_W'(m2) : '0;
    end else begin
      extra2 = MASS_W'(prod);
    end
    mass_sum = mass_run + extra2;
  end

  // Records for this character
  rec_t rec_run, rec_sum;

  always_comb begin
    rec_run.record_kind    = REC_RUN;
    rec_run.element_number = elem_a;
    rec_run.atoms_added    = 7'(a1);
    rec_run.parse_status   = err_q;
    rec_run.atom_total     = 7'(atoms_run);
    rec_run.mass_milli     = mass_run;
    rec_run.final_record   = 1'b0;

    rec_sum.record_kind    = REC_SUM;
    rec_sum.element_number = fin2 ? e2 : '0;
    rec_sum.atoms_added    = fin2 ? 7'(a2) : '0;
    rec_sum.parse_status   = err;
    rec_sum.atom_total     = 7'(atoms);
    rec_sum.mass_milli     = mass_sum;
    rec_sum.final_record   = 1'b1;
  end

  // Next parse state: hold, advance, or return to reset after a last character
  always_comb begin
    phase_d = phase_q;
    sym_d   = sym_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    atoms_d = atoms_q;
    mass_d  = mass_q;
    err_d   = err_q;
    if (acc) begin
      if (last) begin
        phase_d = PH_GAP;
        sym_d   = '0;
        len_d   = '0;
        cnt_d   = '0;
        atoms_d = '0;
        mass_d  = '0;
        err_d   = ST_OK;
      end else begin
        phase_d = ph;
        sym_d   = sym;
        len_d   = len;
        cnt_d   = cnt;
        atoms_d = atoms;
        mass_d  = mass_sum;
        err_d   = err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GAP;
      sym_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      atoms_q <= '0;
      mass_q  <= '0;
      err_q   <= ST_OK;
    end else begin
      phase_q <= phase_d;
      sym_q   <= sym_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      atoms_q <= atoms_d;
      mass_q  <= mass_d;
      err_q   <= err_d;
    end
  end

  // Queue control: push up to two records, pop one
  logic       push0, push1;
  logic [2:0] n_push;

  assign push0  = acc && (fin1 || last);
  assign push1  = acc && fin1 && last;
  assign n_push = {2'b00, push0} + {2'b00, push1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + n_push[1:0];
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      count_q  <= count_q + n_push - {2'b00, pop};
    end
  end

  // Queue storage: run record first, summary after it
  always_ff @(posedge clk_i) begin
    if (push0) begin
      fifo_q[wr_ptr_q] <= fin1 ? rec_run : rec_sum;
    end
    if (push1) begin
      fifo_q[wr_ptr_q + 2'd1] <= rec_sum;
    end
  end

  // Drive the channels
  rec_t head;

  assign head         = fifo_q[rd_ptr_q];
  assign char_i.ready = (count_q <= FifoRoom);

  assign rec_o.valid          = (count_q != '0);
  assign rec_o.record_kind    = head.record_kind;
  assign rec_o.element_number = head.element_number;
  assign rec_o.atoms_added    = head.atoms_added;
  assign rec_o.parse_status   = head.parse_status;
  assign rec_o.atom_total     = head.atom_total;
  assign rec_o.mass_milli     = head.mass_milli;
  assign rec_o.final_record   = head.final_record;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'(FIFO_DEPTH))
    else $error("record queue overflow");

  a_formula_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && last) |=> (phase_q == PH_GAP) && (atoms_q == '0) &&
                      (mass_q == '0) && (err_q == ST_OK))
    else $error("parse state not cleared after last character");

  a_error_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_OK) |-> (phase_q == PH_STOP))
    else $error("error status while still parsing");

  a_count_caps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (atoms_q <= MaxAtoms) && (cnt_q <= MaxAtoms))
    else $error("atom total or run count above cap");
`endif

endmodule

`default_nettype wire
